// File: sv/tdf_pkg.sv
// tdf_pkg: shared types and constants for the duplicate word filter
// no dependencies
package tdf_pkg;

    localparam int DefMaxWords     = 32;
    localparam int DefMaxWordLen   = 16;
    localparam int DefMaxStringLen = 512;
    localparam int RowBytes        = 16;

    localparam logic [7:0] CH_COMMA   = 8'd44;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_DOT     = 8'd46;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;
    localparam logic [7:0] CH_DIGIT_0 = 8'd48;
    localparam logic [7:0] CH_DIGIT_9 = 8'd57;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SYM   = 3'd1;
    localparam logic [2:0] ST_DOT       = 3'd2;
    localparam logic [2:0] ST_TOO_LONG  = 3'd3;
    localparam logic [2:0] ST_WORD_LONG = 3'd4;
    localparam logic [2:0] ST_MANY      = 3'd5;
    localparam logic [2:0] ST_NO_WORDS  = 3'd6;

    typedef struct packed {
        logic [7:0] out_char;
        logic [2:0] status;
        logic       last;
    } res_t;

    // command from front to back: a finished word, possibly with the end of string, or an error
    typedef struct packed {
        logic [RowBytes*8-1:0] word;
        logic [4:0]            len;
        logic                  has_word;
        logic                  fin;
        logic                  err;
        logic [2:0]            err_code;
    } cmd_t;

    function automatic logic is_word_char(input logic [7:0] c);
        return c == CH_NEWLINE || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_DIGIT_0 && c <= CH_DIGIT_9);
    endfunction

endpackage

// File: sv/tdf_if.sv
// tdf_in_if, tdf_out_if: valid/ready channels of the filter
// depends on tdf_pkg
interface tdf_in_if;
    import tdf_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       final_req;
    modport source (output valid, symbol, final_req, input ready);
    modport sink (input valid, symbol, final_req, output ready);
endinterface

interface tdf_out_if;
    import tdf_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic [2:0] status;
    logic       last;
    modport source (output valid, out_char, status, last, input ready);
    modport sink (input valid, out_char, status, last, output ready);
endinterface

// File: sv/tdf_front.sv
// tdf_front: checks characters, collects words, counts words, issues word and error commands
// depends on tdf_pkg, tdf_if
module tdf_front
    import tdf_pkg::*;
#(
    parameter int MAX_WORDS      = DefMaxWords,
    parameter int MAX_WORD_LEN   = DefMaxWordLen,
    parameter int MAX_STRING_LEN = DefMaxStringLen
)
(
    input  logic          clk,
    input  logic          rst_n,
    tdf_in_if.sink        in_ch,
    output logic          cmd_valid,
    output cmd_t          cmd,
    input  logic          cmd_ready
);
    localparam int CW = $clog2(MAX_STRING_LEN + 1);
    localparam int NW = $clog2(MAX_WORDS + 1);

    logic [RowBytes*8-1:0] word_reg, word_next;
    logic [4:0]            len_reg, len_next;
    logic [CW-1:0]         cc_reg, cc_next;
    logic [NW-1:0]         wc_reg, wc_next;
    logic                  disc_reg, disc_next;
    logic                  acc, c_word, c_comma, c_dot, send;
    logic [7:0]            c;

    assign c       = in_ch.symbol;
    assign c_word  = is_word_char(c);
    assign c_comma = c == CH_COMMA;
    assign c_dot   = c == CH_DOT;
    assign in_ch.ready = cmd_ready;
    assign acc = in_ch.valid && in_ch.ready;
    assign cmd_valid = acc && send;

    always_comb
    begin
        word_next = word_reg;
        len_next  = len_reg;
        cc_next   = cc_reg;
        wc_next   = wc_reg;
        disc_next = disc_reg;
        send      = 1'b0;
        cmd.word     = word_reg;
        cmd.len      = len_reg;
        cmd.has_word = len_reg != 5'd0;
        cmd.fin      = in_ch.final_req;
        cmd.err      = 1'b0;
        cmd.err_code = ST_OK;
        if (acc)
        begin
            if (disc_reg)
            begin
                if (in_ch.final_req)
                begin
                    disc_next = 1'b0;
                end
            end
            else
            begin
                send = 1'b1;
                cmd.err = 1'b1;
                if (!(c_word || c_comma || c_dot))
                    cmd.err_code = ST_BAD_SYM;
                else if (cc_reg >= CW'(MAX_STRING_LEN))
                    cmd.err_code = ST_TOO_LONG;
                else if (c_dot != in_ch.final_req)
                    cmd.err_code = ST_DOT;
                else if (c_word && len_reg >= 5'(MAX_WORD_LEN))
                    cmd.err_code = ST_WORD_LONG;
                else if (!c_word && len_reg != 5'd0 && wc_reg >= NW'(MAX_WORDS))
                    cmd.err_code = ST_MANY;
                else
                begin
                    cmd.err = 1'b0;
                    if (c_word)
                    begin
                        send = 1'b0;
                        word_next[len_reg[3:0]*8 +: 8] = c;
                        len_next = len_reg + 5'd1;
                        cc_next  = cc_reg + CW'(1);
                    end
                    else
                    begin
                        word_next = '0;
                        len_next  = '0;
                        cc_next   = c_dot ? '0 : cc_reg + CW'(1);
                        if (c_dot)
                            wc_next = '0;
                        else if (len_reg != 5'd0)
                            wc_next = wc_reg + NW'(1);
                    end
                end
                if (cmd.err)
                begin
                    word_next = '0;
                    len_next  = '0;
                    cc_next   = '0;
                    wc_next   = '0;
                    disc_next = !in_ch.final_req;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
            len_reg  <= '0;
            cc_reg   <= '0;
            wc_reg   <= '0;
            disc_reg <= 1'b0;
        end
        else
        begin
            word_reg <= word_next;
            len_reg  <= len_next;
            cc_reg   <= cc_next;
            wc_reg   <= wc_next;
            disc_reg <= disc_next;
        end
    end
endmodule

// File: sv/tdf_queue.sv
// tdf_queue: two-entry command queue between front and back
// depends on tdf_pkg
module tdf_queue
    import tdf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  cmd_t in_cmd,
    output logic in_ready,
    output logic out_valid,
    output cmd_t out_cmd,
    input  logic out_ready
);
    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_cmd   = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// File: sv/tdf_back.sv
// tdf_back: word table scan, storage and result sequencing
// depends on tdf_pkg, tdf_if
module tdf_back
    import tdf_pkg::*;
#(
    parameter int MAX_WORDS = DefMaxWords
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_ready,
    tdf_out_if.source out_ch
);
    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int NW = $clog2(MAX_WORDS + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_CMP  = 6'b000100,
        S_EMIT = 6'b001000,
        S_END  = 6'b010000,
        S_ONE  = 6'b100000
    } state_t;

    logic [RowBytes*8-1:0] table_mem [MAX_WORDS];
    logic [RowBytes*8-1:0] rd_reg;

    state_t          state_reg, state_next;
    cmd_t            cur_reg, cur_next;
    logic [NW-1:0]   uc_reg, uc_next, wc_reg, wc_next, idx_reg, idx_next;
    logic [4:0]      pos_reg, pos_next;
    logic            comma_reg, comma_next;
    logic            ov_reg, ov_next;
    res_t            res_reg, res_next;
    logic            rd_en, wr_en;
    logic            free;

    assign free = !ov_reg || out_ch.ready;
    assign out_ch.valid    = ov_reg;
    assign out_ch.out_char = res_reg.out_char;
    assign out_ch.status   = res_reg.status;
    assign out_ch.last     = res_reg.last;
    assign cmd_ready = state_reg == S_IDLE;

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_reg <= table_mem[idx_reg[AW-1:0]];
        if (wr_en)
            table_mem[uc_reg[AW-1:0]] <= cur_reg.word;
    end

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        uc_next    = uc_reg;
        wc_next    = wc_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        comma_next = comma_reg;
        ov_next    = ov_reg && !out_ch.ready;
        res_next   = res_reg;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cur_next = cmd;
                    idx_next = '0;
                    if (cmd.err)
                        state_next = S_ONE;
                    else if (!cmd.has_word)
                        state_next = S_END;
                    else if (wc_reg >= NW'(MAX_WORDS))
                        state_next = S_ONE;
                    else
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (idx_reg < uc_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = S_CMP;
                end
                else
                begin
                    wc_next = wc_reg + NW'(1);
                    if (uc_reg < NW'(MAX_WORDS))
                    begin
                        wr_en      = 1'b1;
                        uc_next    = uc_reg + NW'(1);
                        comma_next = uc_reg != '0;
                        pos_next   = '0;
                        state_next = S_EMIT;
                    end
                    else
                        state_next = S_END;
                end
            end
            S_CMP:
            begin
                if (rd_reg == cur_reg.word)
                begin
                    wc_next    = wc_reg + NW'(1);
                    state_next = S_END;
                end
                else
                begin
                    idx_next   = idx_reg + NW'(1);
                    state_next = S_SCAN;
                end
            end
            S_EMIT:
            begin
                if (free)
                begin
                    ov_next = 1'b1;
                    if (comma_reg)
                    begin
                        res_next   = '{CH_COMMA, ST_OK, 1'b0};
                        comma_next = 1'b0;
                    end
                    else
                    begin
                        res_next = '{cur_reg.word[pos_reg[3:0]*8 +: 8], ST_OK, 1'b0};
                        pos_next = pos_reg + 5'd1;
                        if (pos_reg + 5'd1 >= cur_reg.len)
                            state_next = S_END;
                    end
                end
            end
            S_END:
            begin
                if (!cur_reg.fin)
                    state_next = S_IDLE;
                else if (free)
                begin
                    ov_next = 1'b1;
                    uc_next = '0;
                    wc_next = '0;
                    state_next = S_IDLE;
                    if (uc_reg == '0)
                        res_next = '{8'd0, ST_NO_WORDS, 1'b1};
                    else
                        res_next = '{CH_DOT, ST_OK, 1'b1};
                end
            end
            S_ONE:
            begin
                if (free)
                begin
                    ov_next    = 1'b1;
                    res_next   = '{8'd0, cur_reg.err ? cur_reg.err_code : ST_MANY, 1'b1};
                    uc_next    = '0;
                    wc_next    = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            uc_reg    <= '0;
            wc_reg    <= '0;
            idx_reg   <= '0;
            pos_reg   <= '0;
            comma_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            uc_reg    <= uc_next;
            wc_reg    <= wc_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
            comma_reg <= comma_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
    end
endmodule

// File: sv/token_dedup_filter.sv
// token_dedup_filter: top level of the streaming duplicate word filter
// depends on tdf_pkg, tdf_if, tdf_front, tdf_queue, tdf_back
// Word characters are taken one per cycle. A comma or the closing dot hands the word to
// the back end through a two-entry queue; the back end compares it against the stored
// words with one table read per S_SCAN/S_CMP pair, then sends the comma and the word
// bytes one beat per cycle while the output is ready, and the dot or error beat last.
// Input stalls only while the queue is full.
module token_dedup_filter
    import tdf_pkg::*;
#(
    parameter int MAX_WORDS      = DefMaxWords,
    parameter int MAX_WORD_LEN   = DefMaxWordLen,
    parameter int MAX_STRING_LEN = DefMaxStringLen
)
(
    input logic       clk,
    input logic       rst_n,
    tdf_in_if.sink    in_ch,
    tdf_out_if.source out_ch
);
    logic f_valid, f_ready, b_valid, b_ready;
    cmd_t f_cmd, b_cmd;

    tdf_front #(
        .MAX_WORDS(MAX_WORDS),
        .MAX_WORD_LEN(MAX_WORD_LEN),
        .MAX_STRING_LEN(MAX_STRING_LEN)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready)
    );

    tdf_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_cmd(f_cmd), .in_ready(f_ready),
        .out_valid(b_valid), .out_cmd(b_cmd), .out_ready(b_ready)
    );

    tdf_back #(.MAX_WORDS(MAX_WORDS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(b_valid), .cmd(b_cmd), .cmd_ready(b_ready), .out_ch(out_ch)
    );
endmodule

// File: bench/tb_token_dedup_filter.sv
// tb_token_dedup_filter: self-checking bench for the duplicate word filter
// drives strings through tdf_in_if, predicts output beats, checks tdf_out_if
// depends on tdf_pkg, tdf_if and token_dedup_filter
`timescale 1ns / 1ps
module tb_token_dedup_filter;
    import tdf_pkg::*;

    localparam int NumWords   = DefMaxWords;
    localparam int WordLen    = DefMaxWordLen;
    localparam int StringLen  = DefMaxStringLen;
    localparam int StallLimit = 20000;

    typedef struct packed {
        logic [7:0] sym;
        logic       fin;
        logic       has_exp;
        res_t       exp_beat;
    } stim_t;

    logic clk;
    logic rst_n;
    tdf_in_if  in_ch();
    tdf_out_if out_ch();

    token_dedup_filter u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // predictor state
    logic [7:0]           cur_word [RowBytes];
    int                   cur_len;
    logic [RowBytes*8-1:0] kept_words [NumWords];
    int                   kept_count;
    int                   words_seen;
    int                   chars_seen;
    logic                 dropping;

    res_t  pending_beats [$];
    stim_t directed_rows [$];
    int    errors;
    int    idle_cycles;
    int    beats_in;
    int    beats_out;
    int    strings_sent;
    bit    quiet;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic bit word_char(input logic [7:0] c);
        return c == CH_NEWLINE || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_DIGIT_0 && c <= CH_DIGIT_9);
    endfunction

    function automatic res_t mk_beat(input logic [7:0] ch, input logic [2:0] st,
                                     input logic lst);
        res_t r;
        r.out_char = ch;
        r.status   = st;
        r.last     = lst;
        return r;
    endfunction

    function automatic void clear_string();
        foreach (cur_word[i]) cur_word[i] = 8'd0;
        cur_len    = 0;
        kept_count = 0;
        words_seen = 0;
        chars_seen = 0;
    endfunction

    function automatic void raise_error(input logic [2:0] code, input logic fin);
        pending_beats.push_back(mk_beat(8'd0, code, 1'b1));
        clear_string();
        dropping = !fin;
    endfunction

    function automatic bit close_word(input logic fin);
        logic [RowBytes*8-1:0] packed_word;
        bit hit;
        hit = 0;
        if (cur_len == 0)
            return 1;
        if (words_seen >= NumWords)
        begin
            raise_error(ST_MANY, fin);
            return 0;
        end
        for (int i = 0; i < RowBytes; i++)
            packed_word[i*8 +: 8] = cur_word[i];
        for (int i = 0; i < kept_count; i++)
            if (kept_words[i] == packed_word)
                hit = 1;
        if (!hit && kept_count < NumWords)
        begin
            kept_words[kept_count] = packed_word;
            if (kept_count > 0)
                pending_beats.push_back(mk_beat(CH_COMMA, ST_OK, 1'b0));
            for (int j = 0; j < cur_len; j++)
                pending_beats.push_back(mk_beat(cur_word[j], ST_OK, 1'b0));
            kept_count++;
        end
        words_seen++;
        foreach (cur_word[i]) cur_word[i] = 8'd0;
        cur_len = 0;
        return 1;
    endfunction

    function automatic void predict_symbol(input logic [7:0] c, input logic fin);
        if (dropping)
        begin
            if (fin)
            begin
                dropping = 0;
                clear_string();
            end
            return;
        end
        if (!(word_char(c) || c == CH_COMMA || c == CH_DOT))
        begin
            raise_error(ST_BAD_SYM, fin);
            return;
        end
        if (chars_seen >= StringLen)
        begin
            raise_error(ST_TOO_LONG, fin);
            return;
        end
        chars_seen++;
        if ((c == CH_DOT) != fin)
        begin
            raise_error(ST_DOT, fin);
            return;
        end
        if (word_char(c))
        begin
            if (cur_len >= WordLen)
            begin
                raise_error(ST_WORD_LONG, fin);
                return;
            end
            cur_word[cur_len] = c;
            cur_len++;
            return;
        end
        if (c == CH_COMMA)
        begin
            void'(close_word(fin));
            return;
        end
        if (!close_word(fin))
            return;
        if (kept_count == 0)
        begin
            raise_error(ST_NO_WORDS, fin);
            return;
        end
        pending_beats.push_back(mk_beat(CH_DOT, ST_OK, 1'b1));
        clear_string();
    endfunction

    task automatic idle_burst();
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
    endtask

    task automatic send_symbol(input logic [7:0] c, input logic fin);
        idle_burst();
        in_ch.valid     <= 1'b1;
        in_ch.symbol    <= c;
        in_ch.final_req <= fin;
        do @(posedge clk); while (!in_ch.ready);
        predict_symbol(c, fin);
        beats_in++;
        if (fin)
            strings_sent++;
        @(negedge clk);
    endtask

    function automatic logic [7:0] rand_word_char();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
            1: return 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
            2: return 8'($urandom_range(CH_DIGIT_0, CH_DIGIT_9));
            default: return CH_NEWLINE;
        endcase
    endfunction

    // a well formed string from a small vocabulary, with random noise mixed in
    task automatic send_random_string();
        logic [7:0] vocab [4][3];
        int n_words;
        int pick;
        int len;
        foreach (vocab[i, j]) vocab[i][j] = rand_word_char();
        n_words = $urandom_range(1, 8);
        for (int w = 0; w < n_words; w++)
        begin
            pick = $urandom_range(0, 3);
            len  = $urandom_range(1, 3);
            for (int k = 0; k < len; k++)
                send_symbol(vocab[pick][k], 1'b0);
            if ($urandom_range(0, 19) == 0)
                send_symbol(8'($urandom), 1'b0);
            send_symbol(CH_COMMA, 1'b0);
            if ($urandom_range(0, 5) == 0)
                send_symbol(CH_COMMA, 1'b0);
        end
        if ($urandom_range(0, 19) == 0)
            send_symbol(8'($urandom), 1'b1);
        else
            send_symbol(CH_DOT, 1'b1);
    endtask

    task automatic send_word(input int len, input logic [7:0] c);
        for (int k = 0; k < len; k++)
            send_symbol(c, 1'b0);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_beats.size() != 0)
            @(negedge clk);
    endtask

    function automatic stim_t row(input logic [7:0] c, input logic fin, input bit chk,
                                  input logic [2:0] st);
        stim_t s;
        s.sym      = c;
        s.fin      = fin;
        s.has_exp  = chk;
        s.exp_beat = mk_beat(8'd0, st, 1'b1);
        return s;
    endfunction

    // output side: random stalls, compare against oldest expectation
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            beats_out++;
            if (pending_beats.size() == 0)
            begin
                $display("%0t: unexpected beat char=%0d status=%0d last=%0d", $realtime,
                         out_ch.out_char, out_ch.status, out_ch.last);
                errors++;
            end
            else
            begin
                res_t e;
                e = pending_beats.pop_front();
                if (e.out_char !== out_ch.out_char || e.status !== out_ch.status ||
                    e.last !== out_ch.last)
                begin
                    $display("%0t: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                             $realtime, e.out_char, e.status, e.last,
                             out_ch.out_char, out_ch.status, out_ch.last);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > StallLimit)
        begin
            $display("watchdog expired with %0d beats outstanding", pending_beats.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        stim_t s;
        errors       = 0;
        idle_cycles  = 0;
        beats_in     = 0;
        beats_out    = 0;
        strings_sent = 0;
        quiet        = 0;
        dropping     = 0;
        clear_string();
        in_ch.valid     = 1'b0;
        in_ch.symbol    = 8'd0;
        in_ch.final_req = 1'b0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table: error codes and extremes
        directed_rows.push_back(row(CH_DOT, 1'b1, 1, ST_NO_WORDS));
        directed_rows.push_back(row(8'hFF, 1'b1, 1, ST_BAD_SYM));
        directed_rows.push_back(row(8'h00, 1'b0, 1, ST_BAD_SYM));
        directed_rows.push_back(row(CH_DOT, 1'b1, 0, ST_OK));
        directed_rows.push_back(row(CH_UPPER_A, 1'b1, 1, ST_DOT));
        directed_rows.push_back(row(CH_DOT, 1'b0, 1, ST_DOT));
        directed_rows.push_back(row(CH_UPPER_Z, 1'b1, 0, ST_OK));
        directed_rows.push_back(row(CH_COMMA, 1'b0, 0, ST_OK));
        directed_rows.push_back(row(CH_COMMA, 1'b0, 0, ST_OK));
        directed_rows.push_back(row(CH_DOT, 1'b1, 1, ST_NO_WORDS));
        directed_rows.push_back(row(CH_LOWER_A, 1'b0, 0, ST_OK));
        directed_rows.push_back(row(CH_LOWER_Z, 1'b0, 0, ST_OK));
        directed_rows.push_back(row(CH_COMMA, 1'b0, 0, ST_OK));
        directed_rows.push_back(row(CH_DIGIT_0, 1'b0, 0, ST_OK));
        directed_rows.push_back(row(CH_DIGIT_9, 1'b0, 0, ST_OK));
        directed_rows.push_back(row(CH_NEWLINE, 1'b0, 0, ST_OK));
        directed_rows.push_back(row(CH_COMMA, 1'b0, 0, ST_OK));
        directed_rows.push_back(row(CH_LOWER_A, 1'b0, 0, ST_OK));
        directed_rows.push_back(row(CH_LOWER_Z, 1'b0, 0, ST_OK));
        directed_rows.push_back(row(CH_DOT, 1'b1, 0, ST_OK));
        foreach (directed_rows[i])
        begin
            s = directed_rows[i];
            send_symbol(s.sym, s.fin);
            if (s.has_exp && (pending_beats.size() != 1 || pending_beats[0] !== s.exp_beat))
            begin
                $display("%0t: row %0d expected %0d/%0d/%0d, predicted %0d beats",
                         $realtime, i, s.exp_beat.out_char, s.exp_beat.status,
                         s.exp_beat.last, pending_beats.size());
                errors++;
            end
            drain();
        end

        // word too long: max length word, then one more character
        send_word(WordLen, CH_LOWER_A);
        send_symbol(CH_DOT, 1'b1);
        send_word(WordLen + 1, CH_LOWER_A);
        send_symbol(CH_DOT, 1'b1);
        // too many words: distinct words up to the limit, then one more
        for (int w = 0; w <= NumWords; w++)
        begin
            send_symbol(8'(CH_LOWER_A + w % 26), 1'b0);
            send_symbol(8'(CH_DIGIT_0 + w / 26), 1'b0);
            send_symbol(CH_COMMA, 1'b0);
        end
        send_symbol(CH_DOT, 1'b1);
        // sender waits for the block to drain
        drain();

        for (int n = 0; n < 10; n++)
        begin
            if (n == 8)
                quiet = 1;
            send_random_string();
        end
        drain();
        repeat (200) @(negedge clk);

        $display("sent %0d strings, %0d input beats; checked %0d output beats",
                 strings_sent, beats_in, beats_out);
        if (pending_beats.size() != 0)
        begin
            $display("%0t: %0d expected beats never arrived", $realtime, pending_beats.size());
            errors++;
        end
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// File: files.f
sv/tdf_pkg.sv
sv/tdf_if.sv
sv/tdf_front.sv
sv/tdf_queue.sv
sv/tdf_back.sv
sv/token_dedup_filter.sv
bench/tb_token_dedup_filter.sv
